>>> hdl/init_command_list_parser_defines.svh
// Assertion macros for the command list parser checker.
// Needs clk and arst_n in the scope where the macros are used.
`ifndef INIT_COMMAND_LIST_PARSER_DEFINES_SVH
`define INIT_COMMAND_LIST_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ICLP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define ICLP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/iclp_pkg.sv
// Types and constants shared by the command list parser modules.
// No dependencies.
`default_nettype none

package iclp_pkg;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_CMD   = 3'd1;
	localparam logic [2:0] PH_COUNT = 3'd2;
	localparam logic [2:0] PH_ARGS  = 3'd3;
	localparam logic [2:0] PH_DELAY = 3'd4;
	localparam logic [2:0] PH_DONE  = 3'd5;

	localparam logic [1:0] KIND_CMD   = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_DELAY = 2'd2;
	localparam logic [1:0] KIND_END   = 2'd3;

	localparam logic [7:0] DELAY_LONG_CODE = 8'hFF;
	localparam logic [8:0] DELAY_LONG_MS   = 9'd500;

	typedef struct packed {
		logic [7:0] list_byte;
		logic       list_start;
	} iclp_item_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [8:0] out_value;
		logic       list_done;
	} iclp_result_t;

	typedef struct packed {
		logic [2:0] phase;
		logic [7:0] commands_left;
		logic [6:0] args_left;
		logic       delay_pending;
	} iclp_state_t;

endpackage

`default_nettype wire

>>> hdl/iclp_step.sv
// Next-state and result logic for one list byte of the command list parser.
// Depends on iclp_pkg.
`default_nettype none

module iclp_step (
	input  iclp_pkg::iclp_state_t  cur,
	input  iclp_pkg::iclp_item_t   item,
	output iclp_pkg::iclp_state_t  nxt,
	output logic                   emit,
	output iclp_pkg::iclp_result_t res
);

	logic [7:0] b;
	logic [6:0] args_dec;

	assign b        = item.list_byte;
	assign args_dec = cur.args_left - 7'd1;

	always_comb begin
		nxt            = cur;
		emit           = 1'b0;
		res.out_kind   = iclp_pkg::KIND_END;
		res.out_value  = '0;
		res.list_done  = 1'b0;
		if (item.list_start) begin
			nxt.args_left     = '0;
			nxt.delay_pending = 1'b0;
			nxt.commands_left = b;
			if (b == 8'd0) begin
				nxt.phase     = iclp_pkg::PH_DONE;
				emit          = 1'b1;
				res.list_done = 1'b1;
			end else begin
				nxt.phase = iclp_pkg::PH_CMD;
			end
		end else begin
			unique case (cur.phase)
				iclp_pkg::PH_CMD: begin
					nxt.commands_left = cur.commands_left - 8'd1;
					nxt.phase         = iclp_pkg::PH_COUNT;
					emit              = 1'b1;
					res.out_kind      = iclp_pkg::KIND_CMD;
					res.out_value     = {1'b0, b};
				end
				iclp_pkg::PH_COUNT: begin
					nxt.args_left     = b[6:0];
					nxt.delay_pending = b[7];
					if (b[6:0] != 7'd0) begin
						nxt.phase = iclp_pkg::PH_ARGS;
					end else if (b[7]) begin
						nxt.phase = iclp_pkg::PH_DELAY;
					end else if (cur.commands_left == 8'd0) begin
						nxt.phase     = iclp_pkg::PH_DONE;
						emit          = 1'b1;
						res.list_done = 1'b1;
					end else begin
						nxt.phase = iclp_pkg::PH_CMD;
					end
				end
				iclp_pkg::PH_ARGS: begin
					nxt.args_left = args_dec;
					emit          = 1'b1;
					res.out_kind  = iclp_pkg::KIND_DATA;
					res.out_value = {1'b0, b};
					if (args_dec == 7'd0) begin
						if (cur.delay_pending) begin
							nxt.phase = iclp_pkg::PH_DELAY;
						end else if (cur.commands_left == 8'd0) begin
							nxt.phase     = iclp_pkg::PH_DONE;
							res.list_done = 1'b1;
						end else begin
							nxt.phase = iclp_pkg::PH_CMD;
						end
					end
				end
				iclp_pkg::PH_DELAY: begin
					nxt.delay_pending = 1'b0;
					emit              = 1'b1;
					res.out_kind      = iclp_pkg::KIND_DELAY;
					res.out_value     = (b == iclp_pkg::DELAY_LONG_CODE) ?
						iclp_pkg::DELAY_LONG_MS : {1'b0, b};
					if (cur.commands_left == 8'd0) begin
						nxt.phase     = iclp_pkg::PH_DONE;
						res.list_done = 1'b1;
					end else begin
						nxt.phase = iclp_pkg::PH_CMD;
					end
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/init_command_list_parser.sv
// Command list parser top level: input register, parse state, result register.
// Depends on iclp_pkg and iclp_step.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+------------------------
//   item     | item_valid / item_stall     | iclp_item_t   (byte, start)
//   result   | result_valid / result_stall | iclp_result_t (kind, value, done)
//
// One byte per cycle unless results stall; results leave from a register.
// The single parse step between the input and result registers sets that rate.
// Reset puts the parser idle, waiting for a byte with list_start set.
// A stalled result holds; the input register still takes one byte behind it.
`default_nettype none

module init_command_list_parser (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    item_valid,
	output logic                   item_stall,
	input  iclp_pkg::iclp_item_t   item,
	output logic                   result_valid,
	input  wire                    result_stall,
	output iclp_pkg::iclp_result_t result
);

	logic                   valid_s1;
	iclp_pkg::iclp_item_t   item_s1;
	iclp_pkg::iclp_state_t  state_q;
	iclp_pkg::iclp_state_t  state_nxt;
	logic                   emit;
	iclp_pkg::iclp_result_t res;
	logic                   out_free;
	logic                   adv_s1;

	assign out_free   = !result_valid || !result_stall;
	assign adv_s1     = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	iclp_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.emit (emit),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= iclp_pkg::PH_IDLE;
			state_q.commands_left <= '0;
			state_q.args_left     <= '0;
			state_q.delay_pending <= 1'b0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= adv_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			result <= res;
		end
	end

endmodule

`default_nettype wire

>>> hdl/iclp_checker.sv
// Port-level checks for the command list parser, bound to the top level.
// Depends on iclp_pkg and init_command_list_parser_defines.svh.
`default_nettype none
`include "init_command_list_parser_defines.svh"

module iclp_checker (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    result_valid,
	input wire                    result_stall,
	input iclp_pkg::iclp_result_t result
);

	logic held;
	logic is_end;
	logic is_delay;
	logic is_byte;
	logic end_ok;
	logic delay_ok;
	logic byte_ok;

	assign held     = result_valid && result_stall;
	assign is_end   = result_valid && result.out_kind == iclp_pkg::KIND_END;
	assign is_delay = result_valid && result.out_kind == iclp_pkg::KIND_DELAY;
	assign is_byte  = result_valid && (result.out_kind == iclp_pkg::KIND_CMD ||
		result.out_kind == iclp_pkg::KIND_DATA);
	assign end_ok   = result.list_done && result.out_value == 9'd0;
	assign delay_ok = result.out_value <= iclp_pkg::DELAY_LONG_MS;
	assign byte_ok  = !result.out_value[8];

	`ICLP_ASSERT_NEXT(a_result_hold, held, result_valid && $stable(result), "stalled result changed")
	`ICLP_ASSERT_NOW(a_end_is_done, is_end, end_ok, "end marker without list_done")
	`ICLP_ASSERT_NOW(a_delay_range, is_delay, delay_ok, "delay beyond 500 ms")
	`ICLP_ASSERT_NOW(a_byte_range, is_byte, byte_ok, "byte value out of range")

endmodule

bind init_command_list_parser iclp_checker u_iclp_checker (.*);

`default_nettype wire
